FILE: rtl/bir_pkg.sv
// shared types and register codes of the bilinear image rotator
package bir_pkg;

  localparam int unsigned DEF_MAX_SRC_WIDTH  = 256;
  localparam int unsigned DEF_MAX_SRC_HEIGHT = 256;
  localparam int unsigned DEF_MAX_CHANNELS   = 4;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_SRC_WIDTH  = 3'd0,
    REG_SRC_HEIGHT = 3'd1,
    REG_CHAN_COUNT = 3'd2,
    REG_COS_ANGLE  = 3'd3,
    REG_SIN_ANGLE  = 3'd4,
    REG_DST_WIDTH  = 3'd5,
    REG_DST_HEIGHT = 3'd6
  } cfg_reg_e;

  // control from mapping stage to frame store stage
  typedef struct packed {
    logic       valid;
    logic       in_src;
    logic [7:0] fx;
    logic [7:0] fy;
    logic       wr_en;
  } map_ctrl_t;

  // control from frame store stage to blend stages
  typedef struct packed {
    logic       valid;
    logic       in_src;
    logic [7:0] fx;
    logic [7:0] fy;
  } store_ctrl_t;

endpackage

FILE: rtl/bir_map.sv
// coordinate mapping pipeline: offsets, products, sums, inside test and addresses
module bir_map #(
  parameter int unsigned MAX_SRC_WIDTH  = bir_pkg::DEF_MAX_SRC_WIDTH,
  parameter int unsigned MAX_SRC_HEIGHT = bir_pkg::DEF_MAX_SRC_HEIGHT,
  localparam int unsigned AW = $clog2(MAX_SRC_WIDTH * MAX_SRC_HEIGHT)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  in_valid_i,
  input  logic                  action_i,
  input  logic [8:0]            pos_x_i,
  input  logic [8:0]            pos_y_i,
  input  logic [31:0]           pixel_i,
  input  logic [8:0]            src_w_i,
  input  logic [8:0]            src_h_i,
  input  logic [9:0]            dst_w_i,
  input  logic [9:0]            dst_h_i,
  input  logic signed [15:0]    cos_i,
  input  logic signed [15:0]    sin_i,
  output bir_pkg::map_ctrl_t    ctrl_o,
  output logic [3:0][AW-1:0]    rd_addr_o,
  output logic [AW-1:0]         wr_addr_o,
  output logic [31:0]           wr_data_o
);

  function automatic logic [AW-1:0] addr_of(input logic [8:0] x, input logic [8:0] y);
    addr_of = AW'(32'(y) * MAX_SRC_WIDTH + 32'(x));
  endfunction

  // stage a: half-pixel offsets from the output centre
  logic               a_valid_q, a_sample_q;
  logic [8:0]         a_px_q, a_py_q;
  logic [31:0]        a_pix_q;
  logic signed [10:0] a_dx_q, a_dy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (en_i) begin
      a_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_sample_q <= action_i;
      a_px_q     <= pos_x_i;
      a_py_q     <= pos_y_i;
      a_pix_q    <= pixel_i;
      a_dx_q     <= $signed({1'b0, pos_x_i, 1'b0}) - $signed({1'b0, dst_w_i});
      a_dy_q     <= $signed({1'b0, pos_y_i, 1'b0}) - $signed({1'b0, dst_h_i});
    end
  end

  // stage b: the four rotation products
  logic               b_valid_q, b_sample_q;
  logic [8:0]         b_px_q, b_py_q;
  logic [31:0]        b_pix_q;
  logic signed [26:0] b_xc_q, b_ys_q, b_xs_q, b_yc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (en_i) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b_sample_q <= a_sample_q;
      b_px_q     <= a_px_q;
      b_py_q     <= a_py_q;
      b_pix_q    <= a_pix_q;
      b_xc_q     <= 27'(a_dx_q * cos_i);
      b_ys_q     <= 27'(a_dy_q * sin_i);
      b_xs_q     <= 27'(a_dx_q * sin_i);
      b_yc_q     <= 27'(a_dy_q * cos_i);
    end
  end

  // stage c: source point in q15
  logic               c_valid_q, c_sample_q;
  logic [8:0]         c_px_q, c_py_q;
  logic [31:0]        c_pix_q;
  logic signed [27:0] c_x_q, c_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else if (en_i) begin
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_sample_q <= b_sample_q;
      c_px_q     <= b_px_q;
      c_py_q     <= b_py_q;
      c_pix_q    <= b_pix_q;
      c_x_q      <= 28'(b_xc_q) + 28'(b_ys_q) + $signed({5'b0, src_w_i, 14'b0});
      c_y_q      <= 28'(b_yc_q) - 28'(b_xs_q) + $signed({5'b0, src_h_i, 14'b0});
    end
  end

  // stage d: inside test, neighbours and store addresses
  logic       in_src, ld_ok;
  logic [8:0] x1, y1, x2, y2;

  always_comb begin
    in_src = !c_x_q[27] && !c_y_q[27]
          && (c_x_q < $signed({4'b0, src_w_i, 15'b0}))
          && (c_y_q < $signed({4'b0, src_h_i, 15'b0}));
    x1 = c_x_q[23:15];
    y1 = c_y_q[23:15];
    x2 = ({1'b0, x1} + 10'd1 < {1'b0, src_w_i}) ? x1 + 9'd1 : src_w_i - 9'd1;
    y2 = ({1'b0, y1} + 10'd1 < {1'b0, src_h_i}) ? y1 + 9'd1 : src_h_i - 9'd1;
    ld_ok = (c_px_q < src_w_i) && (c_py_q < src_h_i);
  end

  bir_pkg::map_ctrl_t d_ctrl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_ctrl_q <= '0;
    end else if (en_i) begin
      d_ctrl_q.valid  <= c_valid_q && c_sample_q;
      d_ctrl_q.in_src <= in_src;
      d_ctrl_q.fx     <= c_x_q[14:7];
      d_ctrl_q.fy     <= c_y_q[14:7];
      d_ctrl_q.wr_en  <= c_valid_q && !c_sample_q && ld_ok;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rd_addr_o[0] <= addr_of(x1, y1);
      rd_addr_o[1] <= addr_of(x2, y1);
      rd_addr_o[2] <= addr_of(x1, y2);
      rd_addr_o[3] <= addr_of(x2, y2);
      wr_addr_o    <= addr_of(c_px_q, c_py_q);
      wr_data_o    <= c_pix_q;
    end
  end

  assign ctrl_o = d_ctrl_q;

endmodule

FILE: rtl/bir_store.sv
// frame store: one bank per neighbour, all written by loads, read data registered
module bir_store #(
  parameter int unsigned MAX_SRC_WIDTH  = bir_pkg::DEF_MAX_SRC_WIDTH,
  parameter int unsigned MAX_SRC_HEIGHT = bir_pkg::DEF_MAX_SRC_HEIGHT,
  localparam int unsigned DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT,
  localparam int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  bir_pkg::map_ctrl_t    ctrl_i,
  input  logic [3:0][AW-1:0]    rd_addr_i,
  input  logic [AW-1:0]         wr_addr_i,
  input  logic [31:0]           wr_data_i,
  output bir_pkg::store_ctrl_t  ctrl_o,
  output logic [3:0][31:0]      rd_data_o
);

  // four banks with identical contents
  for (genvar k = 0; k < 4; k++) begin : g_bank
    logic [31:0] bank_q [DEPTH];

    always_ff @(posedge clk_i) begin
      if (en_i && ctrl_i.wr_en) begin
        bank_q[wr_addr_i] <= wr_data_i;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rd_data_o[k] <= bank_q[rd_addr_i[k]];
      end
    end
  end

  // control travels alongside the read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_o <= '0;
    end else if (en_i) begin
      ctrl_o.valid  <= ctrl_i.valid;
      ctrl_o.in_src <= ctrl_i.in_src;
      ctrl_o.fx     <= ctrl_i.fx;
      ctrl_o.fy     <= ctrl_i.fy;
    end
  end

endmodule

FILE: rtl/bir_blend.sv
// bilinear blend: horizontal stage, then vertical stage into the output register
module bir_blend (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  bir_pkg::store_ctrl_t  ctrl_i,
  input  logic [3:0][31:0]      rd_data_i,
  input  logic [2:0]            nch_i,
  output logic                  out_valid_o,
  output logic                  inside_o,
  output logic [3:0][7:0]       chan_o
);

  // horizontal blend per channel
  logic [3:0][15:0] top_d, bot_d;
  logic [8:0]       wx;

  always_comb begin
    wx = 9'd256 - {1'b0, ctrl_i.fx};
    for (int k = 0; k < 4; k++) begin
      top_d[k] = 16'(17'(rd_data_i[0][8*k +: 8]) * 17'(wx)
                   + 17'(rd_data_i[1][8*k +: 8]) * 17'(ctrl_i.fx));
      bot_d[k] = 16'(17'(rd_data_i[2][8*k +: 8]) * 17'(wx)
                   + 17'(rd_data_i[3][8*k +: 8]) * 17'(ctrl_i.fx));
    end
  end

  logic             f_valid_q, f_inside_q;
  logic [7:0]       f_fy_q;
  logic [3:0][15:0] f_top_q, f_bot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
    end else if (en_i) begin
      f_valid_q <= ctrl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      f_inside_q <= ctrl_i.in_src;
      f_fy_q     <= ctrl_i.fy;
      f_top_q    <= top_d;
      f_bot_q    <= bot_d;
    end
  end

  // vertical blend, masking outside points and unused channels
  logic [3:0][7:0]  chan_d;
  logic [3:0][24:0] sum;
  logic [8:0]       wy;

  always_comb begin
    wy = 9'd256 - {1'b0, f_fy_q};
    for (int k = 0; k < 4; k++) begin
      sum[k]    = 25'(f_top_q[k]) * 25'(wy) + 25'(f_bot_q[k]) * 25'(f_fy_q);
      chan_d[k] = (f_inside_q && (3'(k) < nch_i)) ? sum[k][23:16] : 8'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (en_i) begin
      out_valid_o <= f_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      inside_o <= f_inside_q;
      chan_o   <= chan_d;
    end
  end

endmodule

FILE: rtl/bilinear_image_rotator_top.sv
// Bilinear image rotator: takes one word per clock (load or sample) and returns one result word
// per sample; loads give no result. Seven register stages (offsets,
// products, sums, inside test and addresses, frame store read, horizontal blend, vertical blend)
// all advance together whenever the output register is empty or being taken, so the rate is one
// word per clock. The frame store holds four banks of MAX_SRC_WIDTH*MAX_SRC_HEIGHT 32-bit words,
// one read port per neighbour; its contents are undefined until loaded and it needs no clearing.
module bilinear_image_rotator_top #(
  parameter int unsigned MAX_SRC_WIDTH  = bir_pkg::DEF_MAX_SRC_WIDTH,
  parameter int unsigned MAX_SRC_HEIGHT = bir_pkg::DEF_MAX_SRC_HEIGHT,
  parameter int unsigned MAX_CHANNELS   = bir_pkg::DEF_MAX_CHANNELS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input words
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        action_i,
  input  logic [8:0]  pos_x_i,
  input  logic [8:0]  pos_y_i,
  input  logic [7:0]  in_chan0_i,
  input  logic [7:0]  in_chan1_i,
  input  logic [7:0]  in_chan2_i,
  input  logic [7:0]  in_chan3_i,
  // result words
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        inside_res_o,
  output logic [7:0]  out_chan0_o,
  output logic [7:0]  out_chan1_o,
  output logic [7:0]  out_chan2_o,
  output logic [7:0]  out_chan3_o,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned AW = $clog2(MAX_SRC_WIDTH * MAX_SRC_HEIGHT);

  // configuration registers
  logic [8:0]         src_w_q, src_h_q;
  logic [2:0]         nch_q;
  logic signed [15:0] cos_q, sin_q;
  logic [9:0]         dst_w_q, dst_h_q;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= 9'd256;
      src_h_q <= 9'd256;
      nch_q   <= 3'd4;
      cos_q   <= 16'sd16384;
      sin_q   <= 16'sd0;
      dst_w_q <= 10'd256;
      dst_h_q <= 10'd256;
    end else if (cfg_wr) begin
      unique case (bir_pkg::cfg_reg_e'(paddr[4:2]))
        bir_pkg::REG_SRC_WIDTH:  src_w_q <= pwdata[8:0];
        bir_pkg::REG_SRC_HEIGHT: src_h_q <= pwdata[8:0];
        bir_pkg::REG_CHAN_COUNT: nch_q   <= pwdata[2:0];
        bir_pkg::REG_COS_ANGLE:  cos_q   <= pwdata[15:0];
        bir_pkg::REG_SIN_ANGLE:  sin_q   <= pwdata[15:0];
        bir_pkg::REG_DST_WIDTH:  dst_w_q <= pwdata[9:0];
        bir_pkg::REG_DST_HEIGHT: dst_h_q <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (bir_pkg::cfg_reg_e'(paddr[4:2]))
      bir_pkg::REG_SRC_WIDTH:  prdata = 32'(src_w_q);
      bir_pkg::REG_SRC_HEIGHT: prdata = 32'(src_h_q);
      bir_pkg::REG_CHAN_COUNT: prdata = 32'(nch_q);
      bir_pkg::REG_COS_ANGLE:  prdata = 32'(cos_q);
      bir_pkg::REG_SIN_ANGLE:  prdata = 32'(sin_q);
      bir_pkg::REG_DST_WIDTH:  prdata = 32'(dst_w_q);
      bir_pkg::REG_DST_HEIGHT: prdata = 32'(dst_h_q);
      default:                 prdata = 32'd0;
    endcase
  end

  // effective sizes: zero reads as one, large values saturate
  logic [8:0] src_w_eff, src_h_eff;
  logic [2:0] nch_eff;

  always_comb begin
    if (src_w_q == 9'd0) src_w_eff = 9'd1;
    else if (32'(src_w_q) > MAX_SRC_WIDTH) src_w_eff = 9'(MAX_SRC_WIDTH);
    else src_w_eff = src_w_q;
    if (src_h_q == 9'd0) src_h_eff = 9'd1;
    else if (32'(src_h_q) > MAX_SRC_HEIGHT) src_h_eff = 9'(MAX_SRC_HEIGHT);
    else src_h_eff = src_h_q;
    if (nch_q == 3'd0) nch_eff = 3'd1;
    else if (32'(nch_q) > MAX_CHANNELS) nch_eff = 3'(MAX_CHANNELS);
    else nch_eff = nch_q;
  end

  // whole pipeline advances when the output register is free
  logic en;
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  bir_pkg::map_ctrl_t   map_ctrl;
  bir_pkg::store_ctrl_t store_ctrl;
  logic [3:0][AW-1:0]   rd_addr;
  logic [AW-1:0]        wr_addr;
  logic [31:0]          wr_data;
  logic [3:0][31:0]     rd_data;
  logic [3:0][7:0]      chan;

  bir_map #(
    .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
    .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT)
  ) u_map (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .in_valid_i (in_valid_i),
    .action_i   (action_i),
    .pos_x_i    (pos_x_i),
    .pos_y_i    (pos_y_i),
    .pixel_i    ({in_chan3_i, in_chan2_i, in_chan1_i, in_chan0_i}),
    .src_w_i    (src_w_eff),
    .src_h_i    (src_h_eff),
    .dst_w_i    (dst_w_q),
    .dst_h_i    (dst_h_q),
    .cos_i      (cos_q),
    .sin_i      (sin_q),
    .ctrl_o     (map_ctrl),
    .rd_addr_o  (rd_addr),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data)
  );

  bir_store #(
    .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
    .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .ctrl_i    (map_ctrl),
    .rd_addr_i (rd_addr),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .ctrl_o    (store_ctrl),
    .rd_data_o (rd_data)
  );

  bir_blend u_blend (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .ctrl_i      (store_ctrl),
    .rd_data_i   (rd_data),
    .nch_i       (nch_eff),
    .out_valid_o (out_valid_o),
    .inside_o    (inside_res_o),
    .chan_o      (chan)
  );

  assign out_chan0_o = chan[0];
  assign out_chan1_o = chan[1];
  assign out_chan2_o = chan[2];
  assign out_chan3_o = chan[3];

  // a point outside the source gives all-zero channels
  a_outside_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !inside_res_o |->
      out_chan0_o == 8'd0 && out_chan1_o == 8'd0 && out_chan2_o == 8'd0 && out_chan3_o == 8'd0)
    else $error("outside point with nonzero channel");

  // a store write never comes with a result in the same stage
  a_write_not_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    map_ctrl.wr_en |-> !map_ctrl.valid)
    else $error("store write and sample in one stage");

  // with one channel in use, channels one and three stay zero
  a_unused_chan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && nch_eff == 3'd1 |-> out_chan1_o == 8'd0 && out_chan3_o == 8'd0)
    else $error("unused channel not zero");

endmodule
